>>> hdl/irpd_pkg.sv
// Shared types and constants for the IR pulse-distance frame decoder.
package irpd_pkg;

    localparam int unsigned DUR_W    = 16;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CFG_IDX_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIT_SPACE_LIMIT = 3'd0,
        CFG_HDR_MARK_MIN    = 3'd1,
        CFG_HDR_MARK_MAX    = 3'd2,
        CFG_HDR_SPACE_MIN   = 3'd3,
        CFG_HDR_SPACE_MAX   = 3'd4
    } t_cfg_idx;

    // Register reset values
    localparam logic [DUR_W-1:0] RST_BIT_SPACE_LIMIT = 16'd1000;
    localparam logic [DUR_W-1:0] RST_HDR_MARK_MIN    = 16'd9000;
    localparam logic [DUR_W-1:0] RST_HDR_MARK_MAX    = 16'd9999;
    localparam logic [DUR_W-1:0] RST_HDR_SPACE_MIN   = 16'd4000;
    localparam logic [DUR_W-1:0] RST_HDR_SPACE_MAX   = 16'd4999;

    typedef struct packed {
        logic [DUR_W-1:0] bit_space_limit;
        logic [DUR_W-1:0] hdr_mark_min;
        logic [DUR_W-1:0] hdr_mark_max;
        logic [DUR_W-1:0] hdr_space_min;
        logic [DUR_W-1:0] hdr_space_max;
    } t_cfg;

    // Timing class of one edge duration
    typedef struct packed {
        logic hdr_mark_ok;
        logic hdr_space_ok;
        logic below_limit;
        logic above_limit;
    } t_edge_class;

endpackage

>>> hdl/ir_pulse_distance_frame_decoder_unit.sv
// Top level of the IR pulse-distance frame decoder.
//
// Input channel (i_in_valid / o_in_ready, i_edge_duration): one request per
// IR edge, carrying the microseconds since the previous edge. A frame is
// 4 + 2*DATA_BITS edges: a start edge, header mark, header space, DATA_BITS
// mark/space pairs sent LSB first, and a trailing end mark.
// Output channel (o_out_valid / i_out_ready, o_data_byte, o_frame_ok): one
// request per frame, issued for the end-mark edge; the byte reads 0 when any
// header or bit timing was out of range.
// Throughput is one edge per cycle unless an end mark waits on a stalled
// receiver. An edge is held in the input register and is classified and
// folded into the frame state as it leaves; the frame result is loaded
// into the output register as the end mark leaves the input register.
// Configuration writes (i_cfg_wr_en, i_cfg_idx, i_cfg_wr_data) take effect
// on the next edge; write only while the decoder is idle.
// Reset clears the frame position, empties both registers and loads the
// default timing windows. When the receiver stalls, the result holds in the
// output register; mid-frame edges keep flowing, and only an end mark waits
// in the input register, which then holds o_in_ready low.
module ir_pulse_distance_frame_decoder_unit
    import irpd_pkg::*;
#(
    parameter int unsigned DATA_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [DUR_W-1:0]     i_edge_duration,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [BYTE_W-1:0]    o_data_byte,
    output logic                 o_frame_ok,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DUR_W-1:0]     i_cfg_wr_data
);

    localparam int unsigned END_EDGE = 3 + 2 * DATA_BITS;
    localparam int unsigned CNT_W    = $clog2(END_EDGE + 1);
    localparam int unsigned BIT_W    = $clog2(BYTE_W);

    t_cfg        w_cfg;
    t_edge_class w_class;

    logic             r_in_valid;
    logic [DUR_W-1:0] r_in_dur;

    logic [CNT_W-1:0]  r_edge_count, n_edge_count;
    logic              r_frame_error, n_frame_error;
    logic              r_held_mark_short, n_held_mark_short;
    logic [BYTE_W-1:0] r_data_shift, n_data_shift;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_data_byte;
    logic              r_frame_ok;

    logic             w_is_end;
    logic             w_out_free;
    logic             w_advance;
    logic [CNT_W-1:0] w_bit_idx;
    logic             w_bit_kept;

    irpd_cfg_regs u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cfg         (w_cfg)
    );

    irpd_edge_classify u_classify (
        .i_duration (r_in_dur),
        .i_cfg      (w_cfg),
        .o_class    (w_class)
    );

    // Handshake: only the end mark needs room in the output register
    assign w_is_end   = r_edge_count >= CNT_W'(END_EDGE);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_advance  = r_in_valid && (!w_is_end || w_out_free);
    assign o_in_ready = !r_in_valid || w_advance;

    // Payload bit position of a bit space edge; bits past the byte are dropped
    assign w_bit_idx  = (r_edge_count >> 1) - CNT_W'(2);
    assign w_bit_kept = {{(32 - CNT_W){1'b0}}, w_bit_idx} < 32'(BYTE_W);

    // Frame state update for the edge leaving the input register
    always_comb begin
        n_edge_count      = r_edge_count + CNT_W'(1);
        n_frame_error     = r_frame_error;
        n_held_mark_short = r_held_mark_short;
        n_data_shift      = r_data_shift;
        if (r_edge_count == CNT_W'(0)) begin
            n_frame_error     = 1'b0;
            n_held_mark_short = 1'b0;
            n_data_shift      = '0;
        end else if (r_edge_count == CNT_W'(1)) begin
            if (!w_class.hdr_mark_ok) begin
                n_frame_error = 1'b1;
            end
        end else if (r_edge_count == CNT_W'(2)) begin
            if (!w_class.hdr_space_ok) begin
                n_frame_error = 1'b1;
            end
        end else if (!w_is_end) begin
            if (r_edge_count[0]) begin
                n_held_mark_short = w_class.below_limit;
            end else if (!r_held_mark_short) begin
                n_frame_error = 1'b1;
            end else if (w_class.below_limit) begin
                if (w_bit_kept) begin
                    n_data_shift[w_bit_idx[BIT_W-1:0]] = 1'b0;
                end
            end else if (w_class.above_limit) begin
                if (w_bit_kept) begin
                    n_data_shift[w_bit_idx[BIT_W-1:0]] = 1'b1;
                end
            end else begin
                n_frame_error = 1'b1;
            end
        end else begin
            n_edge_count = '0;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in_dur <= i_edge_duration;
        end
    end

    // Frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count      <= '0;
            r_frame_error     <= 1'b0;
            r_held_mark_short <= 1'b0;
            r_data_shift      <= '0;
        end else if (w_advance) begin
            r_edge_count      <= n_edge_count;
            r_frame_error     <= n_frame_error;
            r_held_mark_short <= n_held_mark_short;
            r_data_shift      <= n_data_shift;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && w_is_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_advance && w_is_end) begin
            r_data_byte <= r_frame_error ? '0 : r_data_shift;
            r_frame_ok  <= !r_frame_error;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_byte = r_data_byte;
    assign o_frame_ok  = r_frame_ok;

    // Checks
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_edge_count <= CNT_W'(END_EDGE))
        else $error("edge count past the end mark");

    a_bad_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_frame_ok) |-> (r_data_byte == '0))
        else $error("invalid frame carries a nonzero byte");

    a_end_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_is_end) |=> (r_out_valid && r_edge_count == '0))
        else $error("end mark did not produce a result and restart");

    a_stall_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && w_is_end && r_out_valid && !i_out_ready))
        else $error("input stalled without a blocked end mark");

endmodule

>>> hdl/irpd_cfg_regs.sv
// Configuration register bank for the IR pulse-distance frame decoder.
module irpd_cfg_regs
    import irpd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DUR_W-1:0]     i_cfg_wr_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_space_limit <= RST_BIT_SPACE_LIMIT;
            r_cfg.hdr_mark_min    <= RST_HDR_MARK_MIN;
            r_cfg.hdr_mark_max    <= RST_HDR_MARK_MAX;
            r_cfg.hdr_space_min   <= RST_HDR_SPACE_MIN;
            r_cfg.hdr_space_max   <= RST_HDR_SPACE_MAX;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_BIT_SPACE_LIMIT: r_cfg.bit_space_limit <= i_cfg_wr_data;
                CFG_HDR_MARK_MIN:    r_cfg.hdr_mark_min    <= i_cfg_wr_data;
                CFG_HDR_MARK_MAX:    r_cfg.hdr_mark_max    <= i_cfg_wr_data;
                CFG_HDR_SPACE_MIN:   r_cfg.hdr_space_min   <= i_cfg_wr_data;
                CFG_HDR_SPACE_MAX:   r_cfg.hdr_space_max   <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/irpd_edge_classify.sv
// Compares one edge duration against the header windows and the bit limit.
module irpd_edge_classify
    import irpd_pkg::*;
(
    input  logic [DUR_W-1:0] i_duration,
    input  t_cfg             i_cfg,
    output t_edge_class      o_class
);

    // Header windows are inclusive; an empty window never matches
    assign o_class.hdr_mark_ok  = (i_duration >= i_cfg.hdr_mark_min) &&
                                  (i_duration <= i_cfg.hdr_mark_max);
    assign o_class.hdr_space_ok = (i_duration >= i_cfg.hdr_space_min) &&
                                  (i_duration <= i_cfg.hdr_space_max);

    // Exactly at the limit is neither short nor long
    assign o_class.below_limit  = i_duration < i_cfg.bit_space_limit;
    assign o_class.above_limit  = i_duration > i_cfg.bit_space_limit;

endmodule

>>> test/irpd_frame_checker.sv
// Frame checker for the IR pulse-distance decoder: predicts frame results and compares.
module irpd_frame_checker
    import irpd_pkg::*;
#(
    parameter int unsigned DATA_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [DUR_W-1:0]     i_edge_duration,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [BYTE_W-1:0]    i_data_byte,
    input  logic                 i_frame_ok,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DUR_W-1:0]     i_cfg_wr_data,
    output int                   o_errors,
    output int                   o_pending,
    output int                   o_frames,
    output int                   o_good_frames
);
    timeunit 1ns;
    timeprecision 1ps;

    // index of the trailing end mark within a frame
    localparam int unsigned END_EDGE = 3 + 2 * DATA_BITS;
    localparam int unsigned BIT_W    = $clog2(BYTE_W);

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              frame_ok;
    } t_frame_result;

    // shadow of the timing registers and of the frame state
    t_cfg              timing;
    int unsigned       edge_pos;
    logic              bad_frame;
    logic              mark_short;
    logic [BYTE_W-1:0] payload_bits;

    t_frame_result     frames_due[$];
    int                n_err = 0;
    int                n_frames = 0;
    int                n_good = 0;

    // Fold one edge into the frame state; returns 1 with the frame result on the end mark.
    function automatic logic decode_edge(input logic [DUR_W-1:0] dur,
                                         output t_frame_result res);
        int unsigned bit_idx;
        res = '0;
        if (edge_pos == END_EDGE) begin
            res.frame_ok  = !bad_frame;
            res.data_byte = bad_frame ? '0 : payload_bits;
            edge_pos      = 0;
            return 1'b1;
        end
        if (edge_pos == 0) begin
            // frame start wipes whatever the last frame left behind
            bad_frame    = 1'b0;
            mark_short   = 1'b0;
            payload_bits = '0;
        end else if (edge_pos == 1) begin
            if (dur < timing.hdr_mark_min || dur > timing.hdr_mark_max)
                bad_frame = 1'b1;
        end else if (edge_pos == 2) begin
            if (dur < timing.hdr_space_min || dur > timing.hdr_space_max)
                bad_frame = 1'b1;
        end else if (edge_pos % 2 == 1) begin
            mark_short = (dur < timing.bit_space_limit);
        end else begin
            // space: a mark not below the limit or a space right at the limit spoils the frame
            bit_idx = (edge_pos - 4) / 2;
            if (!mark_short || dur == timing.bit_space_limit)
                bad_frame = 1'b1;
            else if (bit_idx < BYTE_W)
                payload_bits[bit_idx[BIT_W-1:0]] = (dur > timing.bit_space_limit);
        end
        edge_pos++;
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_frame_result want;
        t_frame_result fresh;
        if (!i_rst_n) begin
            timing.bit_space_limit = RST_BIT_SPACE_LIMIT;
            timing.hdr_mark_min    = RST_HDR_MARK_MIN;
            timing.hdr_mark_max    = RST_HDR_MARK_MAX;
            timing.hdr_space_min   = RST_HDR_SPACE_MIN;
            timing.hdr_space_max   = RST_HDR_SPACE_MAX;
            edge_pos     = 0;
            bad_frame    = 1'b0;
            mark_short   = 1'b0;
            payload_bits = '0;
            frames_due.delete();
        end else begin
            // result request against the oldest predicted frame
            if (i_out_valid && i_out_ready) begin
                if (frames_due.size() == 0) begin
                    $display("%0t: unexpected result, data_byte %02h frame_ok %0b",
                             $time, i_data_byte, i_frame_ok);
                    n_err++;
                end else begin
                    want = frames_due.pop_front();
                    n_frames++;
                    if (want.frame_ok)
                        n_good++;
                    if (i_data_byte !== want.data_byte) begin
                        $display("%0t: data_byte expected %02h actual %02h",
                                 $time, want.data_byte, i_data_byte);
                        n_err++;
                    end
                    if (i_frame_ok !== want.frame_ok) begin
                        $display("%0t: frame_ok expected %0b actual %0b",
                                 $time, want.frame_ok, i_frame_ok);
                        n_err++;
                    end
                end
            end
            // register writes; unused indexes fall through
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_BIT_SPACE_LIMIT: timing.bit_space_limit = i_cfg_wr_data;
                    CFG_HDR_MARK_MIN:    timing.hdr_mark_min    = i_cfg_wr_data;
                    CFG_HDR_MARK_MAX:    timing.hdr_mark_max    = i_cfg_wr_data;
                    CFG_HDR_SPACE_MIN:   timing.hdr_space_min   = i_cfg_wr_data;
                    CFG_HDR_SPACE_MAX:   timing.hdr_space_max   = i_cfg_wr_data;
                    default: ;
                endcase
            end
            // edge request
            if (i_in_valid && i_in_ready && decode_edge(i_edge_duration, fresh))
                frames_due.push_back(fresh);
        end
        o_errors      <= n_err;
        o_pending     <= frames_due.size();
        o_frames      <= n_frames;
        o_good_frames <= n_good;
    end

endmodule

>>> test/tb_ir_pulse_distance_frame_decoder_unit.sv
// Testbench top for the IR pulse-distance frame decoder: edge stimulus, timing setups, verdict.
module tb_ir_pulse_distance_frame_decoder_unit;
    import irpd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DATA_BITS     = 8;
    localparam int unsigned END_EDGE      = 3 + 2 * DATA_BITS;
    localparam int unsigned BIT_W         = $clog2(BYTE_W);
    localparam int unsigned N_SETUPS      = 8;
    localparam int unsigned PHASE_EDGES   = 200;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam logic [BYTE_W-1:0] DIRECTED_BYTE = 8'hA5;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [DUR_W-1:0]     i_edge_duration = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [BYTE_W-1:0]    o_data_byte;
    logic                 o_frame_ok;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [DUR_W-1:0]     i_cfg_wr_data = '0;

    int n_errors;
    int n_pending;
    int n_frames;
    int n_good;

    // stimulus-side view of the timing registers and the frame position
    t_cfg        timing;
    int unsigned frame_pos = 0;
    int unsigned edges_sent = 0;
    bit          no_gaps = 1'b0;
    bit          hold_off_go = 1'b0;

    always #2 i_clk = ~i_clk;

    ir_pulse_distance_frame_decoder_unit #(
        .DATA_BITS(DATA_BITS)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_edge_duration(i_edge_duration),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_data_byte    (o_data_byte),
        .o_frame_ok     (o_frame_ok),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    irpd_frame_checker #(
        .DATA_BITS(DATA_BITS)
    ) u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_edge_duration(i_edge_duration),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_data_byte    (o_data_byte),
        .i_frame_ok     (o_frame_ok),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_errors       (n_errors),
        .o_pending      (n_pending),
        .o_frames       (n_frames),
        .o_good_frames  (n_good)
    );

    // Offer one edge request, at times with a random gap ahead of it, and wait until it is taken.
    task automatic send_edge(input logic [DUR_W-1:0] dur);
        if (!no_gaps && $urandom_range(99) < 27) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 27);
        end
        i_in_valid      <= 1'b1;
        i_edge_duration <= dur;
        do @(posedge i_clk); while (!o_in_ready);
        frame_pos = (frame_pos == END_EDGE) ? 0 : frame_pos + 1;
        edges_sent++;
    endtask

    // Stop offering, wait for every predicted frame, then let the pipeline empty.
    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (n_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write; the caller drops the enable after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_idx     <= idx;
        i_cfg_wr_data <= val;
        case (idx)
            CFG_BIT_SPACE_LIMIT: timing.bit_space_limit = val;
            CFG_HDR_MARK_MIN:    timing.hdr_mark_min    = val;
            CFG_HDR_MARK_MAX:    timing.hdr_mark_max    = val;
            CFG_HDR_SPACE_MIN:   timing.hdr_space_min   = val;
            CFG_HDR_SPACE_MAX:   timing.hdr_space_max   = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Duration inside a header window, leaning on the window edges; any duration if it is empty.
    function automatic logic [DUR_W-1:0] pick_window(input int unsigned lo, input int unsigned hi);
        int unsigned r;
        r = $urandom_range(9);
        if (lo > hi)
            return DUR_W'($urandom);
        if (r == 0)
            return DUR_W'(lo);
        if (r == 1)
            return DUR_W'(hi);
        return DUR_W'($urandom_range(hi, lo));
    endfunction

    // Duration below the bit limit; with a zero limit nothing qualifies.
    function automatic logic [DUR_W-1:0] pick_short(input int unsigned lim);
        if (lim == 0)
            return '0;
        if ($urandom_range(3) == 0)
            return DUR_W'(lim - 1);
        return DUR_W'($urandom_range(lim - 1, 0));
    endfunction

    // Well-formed frame for the current timing, optionally with one edge spoiled.
    task automatic send_frame(input logic [BYTE_W-1:0] payload, input bit flawed);
        logic [DUR_W-1:0] durs [0:END_EDGE];
        int unsigned lim;
        int unsigned bit_idx;
        int unsigned val;
        int unsigned spot;
        lim = timing.bit_space_limit;
        durs[0] = DUR_W'($urandom);
        durs[1] = pick_window(timing.hdr_mark_min, timing.hdr_mark_max);
        durs[2] = pick_window(timing.hdr_space_min, timing.hdr_space_max);
        for (int unsigned e = 3; e < END_EDGE; e += 2) begin
            bit_idx = (e - 3) / 2;
            durs[e] = pick_short(lim);
            if (bit_idx < BYTE_W && !payload[bit_idx[BIT_W-1:0]]) begin
                durs[e + 1] = pick_short(lim);
            end else if (lim == 65535) begin
                // no long space exists at the top limit
                durs[e + 1] = {DUR_W{1'b1}};
            end else begin
                val = ($urandom_range(1) == 0) ? lim + 1 + $urandom_range(300)
                                               : $urandom_range(65535, lim + 1);
                durs[e + 1] = (val > 65535) ? {DUR_W{1'b1}} : DUR_W'(val);
            end
        end
        durs[END_EDGE] = DUR_W'($urandom);
        if (flawed) begin
            spot = $urandom_range(END_EDGE - 1, 1);
            case ($urandom_range(3))
                0:       durs[spot] = DUR_W'(lim);
                1:       durs[spot] = '0;
                2:       durs[spot] = {DUR_W{1'b1}};
                default: durs[spot] = DUR_W'($urandom);
            endcase
        end
        for (int unsigned e = 0; e <= END_EDGE; e++)
            send_edge(durs[e]);
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial begin : result_side
        @(posedge i_clk);
        forever begin
            if (hold_off_go) begin
                hold_off_go = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_ready <= no_gaps || ($urandom_range(99) >= 27);
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int unsigned lim;
        int unsigned start_count;
        int unsigned pick;
        int unsigned lo;
        int unsigned hi;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        timing.bit_space_limit = RST_BIT_SPACE_LIMIT;
        timing.hdr_mark_min    = RST_HDR_MARK_MIN;
        timing.hdr_mark_max    = RST_HDR_MARK_MAX;
        timing.hdr_space_min   = RST_HDR_SPACE_MIN;
        timing.hdr_space_max   = RST_HDR_SPACE_MAX;
        @(posedge i_clk);

        // Directed frame at reset timing: header at the window edges,
        // marks at 0 and just under the limit, spaces at both sides of it.
        lim = RST_BIT_SPACE_LIMIT;
        send_edge({DUR_W{1'b1}});
        send_edge(RST_HDR_MARK_MIN);
        send_edge(RST_HDR_SPACE_MAX);
        for (int k = 0; k < DATA_BITS; k++) begin
            send_edge((k % 2 == 1) ? DUR_W'(lim - 1) : DUR_W'(0));
            if (k < BYTE_W && DIRECTED_BYTE[k[BIT_W-1:0]])
                send_edge(((k / 2) % 2 == 1) ? {DUR_W{1'b1}} : DUR_W'(lim + 1));
            else
                send_edge(((k / 2) % 2 == 1) ? DUR_W'(lim - 1) : DUR_W'(0));
        end
        send_edge('0);

        // Random frames under a series of timing setups
        for (int setup = 0; setup < N_SETUPS; setup++) begin
            drain_and_settle();
            case (setup)
                0: ;
                1: begin
                    // zero limit: every frame fails; header windows wide open
                    write_reg(CFG_BIT_SPACE_LIMIT, '0);
                    write_reg(CFG_HDR_MARK_MIN, '0);
                    write_reg(CFG_HDR_MARK_MAX, {DUR_W{1'b1}});
                    write_reg(CFG_HDR_SPACE_MIN, '0);
                    write_reg(CFG_HDR_SPACE_MAX, {DUR_W{1'b1}});
                    write_reg(CFG_IDX_W'(CFG_HDR_SPACE_MAX + 1 + $urandom_range(2)),
                              DUR_W'($urandom));
                end
                2: begin
                    // top limit, single-value header windows at the extremes
                    write_reg(CFG_BIT_SPACE_LIMIT, {DUR_W{1'b1}});
                    write_reg(CFG_HDR_MARK_MIN, {DUR_W{1'b1}});
                    write_reg(CFG_HDR_MARK_MAX, {DUR_W{1'b1}});
                    write_reg(CFG_HDR_SPACE_MIN, '0);
                    write_reg(CFG_HDR_SPACE_MAX, '0);
                end
                3: begin
                    // empty header windows: min above max
                    write_reg(CFG_BIT_SPACE_LIMIT, DUR_W'(1));
                    write_reg(CFG_HDR_MARK_MIN, {DUR_W{1'b1}});
                    write_reg(CFG_HDR_MARK_MAX, '0);
                    write_reg(CFG_HDR_SPACE_MIN, DUR_W'(5000));
                    write_reg(CFG_HDR_SPACE_MAX, DUR_W'(4999));
                end
                7: begin
                    write_reg(CFG_BIT_SPACE_LIMIT, RST_BIT_SPACE_LIMIT);
                    write_reg(CFG_HDR_MARK_MIN, RST_HDR_MARK_MIN);
                    write_reg(CFG_HDR_MARK_MAX, RST_HDR_MARK_MAX);
                    write_reg(CFG_HDR_SPACE_MIN, RST_HDR_SPACE_MIN);
                    write_reg(CFG_HDR_SPACE_MAX, RST_HDR_SPACE_MAX);
                    write_reg(CFG_IDX_W'(CFG_HDR_SPACE_MAX + 1 + $urandom_range(2)),
                              DUR_W'($urandom));
                end
                default: begin
                    write_reg(CFG_BIT_SPACE_LIMIT, DUR_W'($urandom_range(3000, 1)));
                    lo = $urandom_range(65535);
                    hi = lo + $urandom_range(2000);
                    write_reg(CFG_HDR_MARK_MIN, DUR_W'(lo));
                    write_reg(CFG_HDR_MARK_MAX, (hi > 65535) ? {DUR_W{1'b1}} : DUR_W'(hi));
                    lo = $urandom_range(65535);
                    hi = lo + $urandom_range(2000);
                    write_reg(CFG_HDR_SPACE_MIN, DUR_W'(lo));
                    write_reg(CFG_HDR_SPACE_MAX, (hi > 65535) ? {DUR_W{1'b1}} : DUR_W'(hi));
                end
            endcase
            i_cfg_wr_en <= 1'b0;
            no_gaps = (setup == 2);
            if (setup == 0)
                hold_off_go = 1'b1;

            // mostly aligned frames, some spoiled, some bursts of stray edges
            start_count = edges_sent;
            while (edges_sent - start_count < PHASE_EDGES) begin
                pick = $urandom_range(99);
                if (pick < 80) begin
                    while (frame_pos != 0)
                        send_edge(DUR_W'($urandom));
                    send_frame((pick < 8) ? '0 : (pick < 16) ? {BYTE_W{1'b1}} :
                               BYTE_W'($urandom), $urandom_range(3) == 0);
                end else begin
                    repeat ($urandom_range(6, 1))
                        send_edge(DUR_W'($urandom));
                end
            end
        end

        drain_and_settle();
        $display("covered %0d edges over %0d timing setups, incl. a long result hold-off",
                 edges_sent, N_SETUPS);
        $display("%0d frame results checked, %0d of them valid", n_frames, n_good);
        if (n_errors == 0)
            $display("tb_ir_pulse_distance_frame_decoder_unit: clean");
        else
            $display("tb_ir_pulse_distance_frame_decoder_unit: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("tb_ir_pulse_distance_frame_decoder_unit: errors");
        $finish;
    end

endmodule
